// ===== rtl/olc_pkg.sv =====
// Shared types and constants for the ordered list core.
// No dependencies; imported by olc_cell and ordered_list_with_compaction_core.
package olc_pkg;

    localparam int CMD_W       = 3;
    localparam int INDEX_W     = 4;
    localparam int PORT_VAL_W  = 32;
    localparam int STATUS_W    = 2;
    localparam int LEN_W       = 5;
    localparam int IN_TDATA_W  = 40;
    localparam int OUT_TDATA_W = 40;

    typedef enum logic [CMD_W-1:0] {
        CMD_GET          = 3'd0,
        CMD_SET          = 3'd1,
        CMD_APPEND       = 3'd2,
        CMD_REMOVE_ALL   = 3'd3,
        CMD_REMOVE_FIRST = 3'd4
    } cmd_t;

    typedef enum logic [STATUS_W-1:0] {
        STAT_OK      = 2'd0,
        STAT_RANGE   = 2'd1,
        STAT_FULL    = 2'd2,
        STAT_NOMATCH = 2'd3
    } status_t;

    // Per-cycle instruction broadcast to every cell of the row.
    typedef enum logic [1:0] {
        CELL_HOLD       = 2'd0,
        CELL_LOAD       = 2'd1,   // pointed cell takes wdata
        CELL_SHIFT      = 2'd2,   // every cell takes its upper neighbor
        CELL_SHIFT_LOAD = 2'd3    // shift, but pointed cell takes wdata
    } cell_op_t;

endpackage

// ===== rtl/olc_cell.sv =====
// One storage cell of the list row: holds a single entry.
// Depends on olc_pkg (cell_op_t).
module olc_cell #(
    parameter int VALUE_WIDTH = 32,
    parameter int PTR_WIDTH   = 4,
    parameter int CELL_INDEX  = 0
) (
    input  logic                   aclk,
    input  olc_pkg::cell_op_t      op,
    input  logic [PTR_WIDTH-1:0]   ptr,
    input  logic [VALUE_WIDTH-1:0] wdata,
    input  logic [VALUE_WIDTH-1:0] upper,
    output logic [VALUE_WIDTH-1:0] entry
);
    import olc_pkg::*;

    localparam logic [PTR_WIDTH-1:0] MY_POS = PTR_WIDTH'(CELL_INDEX);

    logic [VALUE_WIDTH-1:0] entry_reg;
    logic [VALUE_WIDTH-1:0] entry_next;
    logic                   sel;

    assign sel = (ptr == MY_POS);

    always_comb begin
        entry_next = entry_reg;
        case (op)
            CELL_LOAD: begin
                if (sel) begin
                    entry_next = wdata;
                end
            end
            CELL_SHIFT:      entry_next = upper;
            CELL_SHIFT_LOAD: entry_next = sel ? wdata : upper;
            default: ;
        endcase
    end

    always_ff @(posedge aclk) begin
        entry_reg <= entry_next;
    end

    assign entry = entry_reg;

endmodule

// ===== rtl/ordered_list_with_compaction_core.sv =====
// Ordered list with compaction: top level, control sequencer and output skid.
// Depends on olc_pkg and olc_cell (row of CAPACITY storage cells).
//
//  channel | dir | handshake          | payload (low bit first)
//  --------+-----+--------------------+----------------------------------------
//  s_      | in  | s_tvalid/s_tready  | cmd[2:0] index[6:3] value[38:7] pad
//  m_      | out | m_tvalid/m_tready  | read_value[31:0] status[33:32]
//          |     |                    | length_after[38:34] pad
//
// Get, set, append and unknown commands produce their result in the cycle
// the request is accepted; it is registered on m_, or in the skid while m_ stalls.
// Remove commands run in S_REMOVE (an empty list gets no-match on acceptance):
// the row rotates once through its n live cells, n being the length when the
// request is accepted, one entry per cycle passing through the head comparator.
// aresetn clears length, sequencer and output valids; entry contents are
// undefined until written and never read beyond the length.
// A result waiting on m_ does not block the next request; a second one goes
// to a skid register, and s_tready drops only while the skid is occupied
// or a removal is in progress.
module ordered_list_with_compaction_core #(
    parameter int CAPACITY    = 16,
    parameter int VALUE_WIDTH = 32
) (
    input  logic                             aclk,
    input  logic                             aresetn,
    // s_tdata: cmd, index, value, zero pad
    input  logic                             s_tvalid,
    output logic                             s_tready,
    input  logic [olc_pkg::IN_TDATA_W-1:0]   s_tdata,
    // m_tdata: read_value, status, length_after, zero pad
    output logic                             m_tvalid,
    input  logic                             m_tready,
    output logic [olc_pkg::OUT_TDATA_W-1:0]  m_tdata
);
    import olc_pkg::*;

    localparam int CW = $clog2(CAPACITY + 1);   // length counter
    localparam int PW = $clog2(CAPACITY);       // cell pointer
    localparam int NGET = (CAPACITY < 16) ? CAPACITY : 16;  // cells reachable by index

    typedef enum logic {
        S_IDLE,
        S_REMOVE
    } state_t;

    // ---- request fields ----
    cmd_t                    req_cmd;
    logic [INDEX_W-1:0]      req_idx;
    logic [PORT_VAL_W-1:0]   req_val;
    logic [VALUE_WIDTH+PORT_VAL_W-1:0] val_ext;
    logic [VALUE_WIDTH-1:0]  val_in;

    assign req_cmd = cmd_t'(s_tdata[2:0]);
    assign req_idx = s_tdata[6:3];
    assign req_val = s_tdata[38:7];
    assign val_ext = {{VALUE_WIDTH{1'b0}}, req_val};
    assign val_in  = val_ext[VALUE_WIDTH-1:0];

    // ---- registers ----
    state_t                  state_reg, state_next;
    logic [CW-1:0]           count_reg, count_next;
    logic [VALUE_WIDTH-1:0]  rm_value_reg, rm_value_next;
    logic                    rm_first_reg, rm_first_next;
    logic                    rm_hit_reg, rm_hit_next;
    logic [CW-1:0]           rm_left_reg, rm_left_next;   // entries still to pass the head
    logic [CW-1:0]           rm_kept_reg, rm_kept_next;
    logic [PW-1:0]           rm_ptr_reg, rm_ptr_next;     // slot for next kept entry
    logic                    m_valid_reg, m_valid_next;
    logic [OUT_TDATA_W-1:0]  m_data_reg, m_data_next;
    logic                    skid_valid_reg, skid_valid_next;
    logic [OUT_TDATA_W-1:0]  skid_data_reg, skid_data_next;

    // ---- cell row ----
    logic [VALUE_WIDTH-1:0]  entries [CAPACITY];
    cell_op_t                cell_op;
    logic [PW-1:0]           cell_ptr;
    logic [VALUE_WIDTH-1:0]  cell_wdata;

    for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
        logic [VALUE_WIDTH-1:0] upper;
        if (g == CAPACITY - 1) begin : g_top
            assign upper = entries[g];
        end else begin : g_mid
            assign upper = entries[g + 1];
        end
        olc_cell #(
            .VALUE_WIDTH (VALUE_WIDTH),
            .PTR_WIDTH   (PW),
            .CELL_INDEX  (g)
        ) u_cell (
            .aclk  (aclk),
            .op    (cell_op),
            .ptr   (cell_ptr),
            .wdata (cell_wdata),
            .upper (upper),
            .entry (entries[g])
        );
    end

    // ---- datapath helpers ----
    logic                    accept;
    logic [CW+INDEX_W-1:0]   idx_ext;
    logic [CW+INDEX_W-1:0]   cnt_ext;
    logic                    in_range;
    logic [PW-1:0]           idx_ptr;
    logic [PW-1:0]           cnt_ptr;
    logic [CW-1:0]           cnt_m1;
    logic [VALUE_WIDTH-1:0]  get_entry;
    logic [VALUE_WIDTH+PORT_VAL_W-1:0] get_ext;
    logic [VALUE_WIDTH-1:0]  head;
    logic                    drop;
    logic                    keep;

    assign s_tready = (state_reg == S_IDLE) && !skid_valid_reg;
    assign accept   = s_tvalid && s_tready;

    assign idx_ext  = {{CW{1'b0}}, req_idx};
    assign cnt_ext  = {{INDEX_W{1'b0}}, count_reg};
    assign in_range = (idx_ext < cnt_ext);          // also implies index < CAPACITY
    assign idx_ptr  = idx_ext[PW-1:0];
    assign cnt_ptr  = count_reg[PW-1:0];
    assign cnt_m1   = count_reg - CW'(1);

    // read mux over the cells an index can reach
    always_comb begin
        get_entry = '0;
        for (int i = 0; i < NGET; i++) begin
            if (req_idx == INDEX_W'(i)) begin
                get_entry = entries[i];
            end
        end
    end
    assign get_ext = {{PORT_VAL_W{1'b0}}, get_entry};

    // head comparator for the rotating removal
    assign head = entries[0];
    assign drop = (head == rm_value_reg) && !(rm_first_reg && rm_hit_reg);
    assign keep = !drop;

    // ---- result assembly ----
    logic                    push;
    logic [PORT_VAL_W-1:0]   push_rv;
    status_t                 push_st;
    logic [CW-1:0]           push_cnt;
    logic [CW+LEN_W-1:0]     push_cnt_ext;
    logic [OUT_TDATA_W-1:0]  push_data;

    assign push_cnt_ext = {{LEN_W{1'b0}}, push_cnt};
    assign push_data    = {1'b0, push_cnt_ext[LEN_W-1:0], push_st, push_rv};

    // ---- sequencer ----
    always_comb begin
        state_next    = state_reg;
        count_next    = count_reg;
        rm_value_next = rm_value_reg;
        rm_first_next = rm_first_reg;
        rm_hit_next   = rm_hit_reg;
        rm_left_next  = rm_left_reg;
        rm_kept_next  = rm_kept_reg;
        rm_ptr_next   = rm_ptr_reg;

        cell_op    = CELL_HOLD;
        cell_ptr   = idx_ptr;
        cell_wdata = val_in;

        push     = 1'b0;
        push_rv  = '0;
        push_st  = STAT_OK;
        push_cnt = count_reg;

        unique case (state_reg)
            S_IDLE: begin
                if (accept) begin
                    case (req_cmd)
                        CMD_GET: begin
                            push = 1'b1;
                            if (in_range) begin
                                push_rv = get_ext[PORT_VAL_W-1:0];
                            end else begin
                                push_st = STAT_RANGE;
                            end
                        end
                        CMD_SET: begin
                            push = 1'b1;
                            if (in_range) begin
                                cell_op = CELL_LOAD;
                            end else begin
                                push_st = STAT_RANGE;
                            end
                        end
                        CMD_APPEND: begin
                            push = 1'b1;
                            if (count_reg != CW'(CAPACITY)) begin
                                cell_op    = CELL_LOAD;
                                cell_ptr   = cnt_ptr;
                                count_next = count_reg + CW'(1);
                                push_cnt   = count_reg + CW'(1);
                            end else begin
                                push_st = STAT_FULL;
                            end
                        end
                        CMD_REMOVE_ALL, CMD_REMOVE_FIRST: begin
                            if (count_reg == '0) begin
                                push    = 1'b1;
                                push_st = STAT_NOMATCH;
                            end else begin
                                state_next    = S_REMOVE;
                                rm_value_next = val_in;
                                rm_first_next = (req_cmd == CMD_REMOVE_FIRST);
                                rm_hit_next   = 1'b0;
                                rm_left_next  = count_reg;
                                rm_kept_next  = '0;
                                rm_ptr_next   = cnt_m1[PW-1:0];
                            end
                        end
                        default: begin
                            push = 1'b1;   // unused codes: no change, status ok
                        end
                    endcase
                end
            end
            S_REMOVE: begin
                // whole row shifts down; a kept head re-enters behind the
                // already kept entries
                cell_op      = keep ? CELL_SHIFT_LOAD : CELL_SHIFT;
                cell_ptr     = rm_ptr_reg;
                cell_wdata   = head;
                rm_hit_next  = rm_hit_reg || drop;
                rm_kept_next = rm_kept_reg + CW'(keep);
                rm_ptr_next  = keep ? rm_ptr_reg : rm_ptr_reg - PW'(1);
                rm_left_next = rm_left_reg - CW'(1);
                if (rm_left_reg == CW'(1)) begin
                    state_next = S_IDLE;
                    count_next = rm_kept_next;
                    push       = 1'b1;
                    push_cnt   = rm_kept_next;
                    push_st    = rm_hit_next ? STAT_OK : STAT_NOMATCH;
                end
            end
        endcase
    end

    // ---- output register and skid ----
    always_comb begin
        m_valid_next    = m_valid_reg;
        m_data_next     = m_data_reg;
        skid_valid_next = skid_valid_reg;
        skid_data_next  = skid_data_reg;
        if (push) begin
            // skid is always empty when a result is produced
            if (!m_valid_reg || m_tready) begin
                m_valid_next = 1'b1;
                m_data_next  = push_data;
            end else begin
                skid_valid_next = 1'b1;
                skid_data_next  = push_data;
            end
        end else if (m_valid_reg && m_tready) begin
            if (skid_valid_reg) begin
                m_data_next     = skid_data_reg;
                skid_valid_next = 1'b0;
            end else begin
                m_valid_next = 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= S_IDLE;
            count_reg      <= '0;
            m_valid_reg    <= 1'b0;
            skid_valid_reg <= 1'b0;
        end else begin
            state_reg      <= state_next;
            count_reg      <= count_next;
            m_valid_reg    <= m_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
        rm_value_reg  <= rm_value_next;
        rm_first_reg  <= rm_first_next;
        rm_hit_reg    <= rm_hit_next;
        rm_left_reg   <= rm_left_next;
        rm_kept_reg   <= rm_kept_next;
        rm_ptr_reg    <= rm_ptr_next;
        m_data_reg    <= m_data_next;
        skid_data_reg <= skid_data_next;
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;

endmodule
